### hw/rtl/cbsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsg_pkg
// shared types and fixed field widths of the bezier segment generator
// ----------------------------------------------------------------------------
package cbsg_pkg;

  localparam int COLOR_W = 16;
  localparam int STEPS_W = 7;

  // per-segment control that travels beside the datapath
  typedef struct packed {
    logic               first;
    logic               last;
    logic               fill;
    logic [COLOR_W-1:0] color;
  } ctl_t;

endpackage

### hw/rtl/cbsg_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsg_weights
// two stages forming the bernstein weights u^3, 3u^2k, 3uk^2, k^3 and n^3
// ----------------------------------------------------------------------------
module cbsg_weights #(
  parameter int SB = 7,
  parameter int DW = 21,
  parameter int CB = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  cbsg_pkg::ctl_t              ctl_i,
  input  logic [SB-1:0]               k_i,
  input  logic [SB-1:0]               u_i,
  input  logic [SB-1:0]               n_i,
  input  logic [8*CB-1:0]             pts_i,
  output logic                        vld_o,
  output cbsg_pkg::ctl_t              ctl_o,
  output logic [3:0][DW-1:0]          w_o,
  output logic [DW-1:0]               d_o,
  output logic [8*CB-1:0]             pts_o
);

  logic                s1_vld_q;
  cbsg_pkg::ctl_t      s1_ctl_q;
  logic [2*SB-1:0]     u2_q, k2_q, uk_q, n2_q;
  logic [SB-1:0]       s1_k_q, s1_u_q, s1_n_q;
  logic [8*CB-1:0]     s1_pts_q;
  logic [3:0][DW-1:0]  w_d;
  logic [DW-1:0]       d_d;
  logic [DW-1:0]       t1, t2;

  // stage one: squares and cross product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u2_q     <= {{SB{1'b0}}, u_i} * {{SB{1'b0}}, u_i};
      k2_q     <= {{SB{1'b0}}, k_i} * {{SB{1'b0}}, k_i};
      uk_q     <= {{SB{1'b0}}, u_i} * {{SB{1'b0}}, k_i};
      n2_q     <= {{SB{1'b0}}, n_i} * {{SB{1'b0}}, n_i};
      s1_k_q   <= k_i;
      s1_u_q   <= u_i;
      s1_n_q   <= n_i;
      s1_ctl_q <= ctl_i;
      s1_pts_q <= pts_i;
    end
  end

  // stage two: cubes and the factor of three
  always_comb begin
    t1     = DW'(u2_q) * DW'(s1_k_q);
    t2     = DW'(uk_q) * DW'(s1_k_q);
    w_d[0] = DW'(u2_q) * DW'(s1_u_q);
    w_d[1] = (t1 << 1) + t1;
    w_d[2] = (t2 << 1) + t2;
    w_d[3] = DW'(k2_q) * DW'(s1_k_q);
    d_d    = DW'(n2_q) * DW'(s1_n_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o   <= w_d;
      d_o   <= d_d;
      ctl_o <= s1_ctl_q;
      pts_o <= s1_pts_q;
    end
  end

endmodule

### hw/rtl/cbsg_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsg_combine
// weighted products of the control points, then sum, sign and magnitude
// ----------------------------------------------------------------------------
module cbsg_combine #(
  parameter int DW = 21,
  parameter int CB = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  cbsg_pkg::ctl_t         ctl_i,
  input  logic [3:0][DW-1:0]     w_i,
  input  logic [DW-1:0]          d_i,
  input  logic [8*CB-1:0]        pts_i,
  output logic                   vld_o,
  output cbsg_pkg::ctl_t         ctl_o,
  output logic [1:0][DW+CB-1:0]  mag_o,
  output logic [1:0]             neg_o,
  output logic [DW-1:0]          d_o,
  output logic [2*CB-1:0]        p0_o
);

  localparam int PW = DW + CB + 1;
  localparam int NW = PW + 2;
  localparam int MW = DW + CB;

  logic                        s3_vld_q;
  cbsg_pkg::ctl_t              s3_ctl_q;
  logic signed [PW-1:0]        pr_q [2][4];
  logic [DW-1:0]               s3_d_q;
  logic [2*CB-1:0]             s3_p0_q;
  logic signed [NW-1:0]        num  [2];
  logic [1:0][MW-1:0]          mag_d;
  logic [1:0]                  neg_d;

  // stage three: one multiplier per point and axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 2; a++) begin
        for (int j = 0; j < 4; j++) begin
          pr_q[a][j] <= PW'($signed({1'b0, w_i[j]})) *
                        PW'($signed(pts_i[(2*j+a)*CB +: CB]));
        end
      end
      s3_ctl_q <= ctl_i;
      s3_d_q   <= d_i;
      s3_p0_q  <= pts_i[2*CB-1:0];
    end
  end

  // stage four: sum and split into sign and magnitude
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      num[a]   = NW'(pr_q[a][0]) + NW'(pr_q[a][1]) + NW'(pr_q[a][2]) + NW'(pr_q[a][3]);
      neg_d[a] = num[a][NW-1];
      mag_d[a] = neg_d[a] ? MW'(-num[a]) : MW'(num[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= mag_d;
      neg_o <= neg_d;
      ctl_o <= s3_ctl_q;
      d_o   <= s3_d_q;
      p0_o  <= s3_p0_q;
    end
  end

endmodule

### hw/rtl/cbsg_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsg_divide
// pipelined restoring divider, one quotient bit per stage, both axes
// ----------------------------------------------------------------------------
module cbsg_divide #(
  parameter int DW = 21,
  parameter int CB = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  cbsg_pkg::ctl_t         ctl_i,
  input  logic [1:0][DW+CB-1:0]  mag_i,
  input  logic [1:0]             neg_i,
  input  logic [DW-1:0]          d_i,
  input  logic [2*CB-1:0]        p0_i,
  output logic                   vld_o,
  output cbsg_pkg::ctl_t         ctl_o,
  output logic [1:0][CB-1:0]     quo_o,
  output logic [1:0]             neg_o,
  output logic [2*CB-1:0]        p0_o
);

  // the quotient is known to fit in CB bits, so the top of the
  // dividend is already a valid partial remainder
  logic [1:0][DW-1:0]  rem_q [CB];
  logic [1:0][CB-1:0]  dq_q  [CB];
  logic                vld_q [CB];
  cbsg_pkg::ctl_t      ctl_q [CB];
  logic [1:0]          neg_q [CB];
  logic [DW-1:0]       d_q   [CB];
  logic [2*CB-1:0]     p0_q  [CB];

  for (genvar s = 0; s < CB; s++) begin : g_stage
    logic [1:0][DW-1:0]  rem_in;
    logic [1:0][CB-1:0]  dq_in;
    logic                vld_in;
    cbsg_pkg::ctl_t      ctl_in;
    logic [1:0]          neg_in;
    logic [DW-1:0]       d_in;
    logic [2*CB-1:0]     p0_in;
    logic [1:0][DW-1:0]  rem_d;
    logic [1:0][CB-1:0]  dq_d;
    logic [DW:0]         trial [2];
    logic [1:0]          ge;

    if (s == 0) begin : g_head
      always_comb begin
        for (int a = 0; a < 2; a++) begin
          rem_in[a] = mag_i[a][DW+CB-1:CB];
          dq_in[a]  = mag_i[a][CB-1:0];
        end
      end
      assign vld_in = vld_i;
      assign ctl_in = ctl_i;
      assign neg_in = neg_i;
      assign d_in   = d_i;
      assign p0_in  = p0_i;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign dq_in  = dq_q[s-1];
      assign vld_in = vld_q[s-1];
      assign ctl_in = ctl_q[s-1];
      assign neg_in = neg_q[s-1];
      assign d_in   = d_q[s-1];
      assign p0_in  = p0_q[s-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      for (int a = 0; a < 2; a++) begin
        trial[a] = {rem_in[a], dq_in[a][CB-1]};
        ge[a]    = trial[a] >= {1'b0, d_in};
        rem_d[a] = ge[a] ? DW'(trial[a] - {1'b0, d_in}) : DW'(trial[a]);
        dq_d[a]  = {dq_in[a][CB-2:0], ge[a]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        dq_q[s]  <= dq_d;
        ctl_q[s] <= ctl_in;
        neg_q[s] <= neg_in;
        d_q[s]   <= d_in;
        p0_q[s]  <= p0_in;
      end
    end
  end

  assign vld_o = vld_q[CB-1];
  assign ctl_o = ctl_q[CB-1];
  assign quo_o = dq_q[CB-1];
  assign neg_o = neg_q[CB-1];
  assign p0_o  = p0_q[CB-1];

endmodule

### hw/rtl/cubic_bezier_segment_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_segment_generator
// flattens one cubic bezier curve into n line segments or fan triangles
//
//  channel   direction  tdata / tuser / tlast
//  s_axis    in         control points, steps, pen colour / fill flag / -
//  m_axis    out        from, to, apex, colour / triangle flag / last segment
//
//  an item issues max(1, min(steps, MAX_STEPS)) segments, one per cycle
//  while the output register can load, from the step sequencer; the next
//  item is taken once its last segment has been issued
//  segments pass the weights, combine and bit-per-stage divider stages
//  all pipeline stages advance together when the output register can load
//  reset clears the sequencer and every valid bit
// ----------------------------------------------------------------------------
module cubic_bezier_segment_generator #(
  parameter int MAX_STEPS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, steps, pen_color
  input  logic [((8*COORD_BITS+cbsg_pkg::STEPS_W+cbsg_pkg::COLOR_W+7)/8)*8-1:0]
                              s_axis_tdata,
  // func
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // from_x, from_y, to_x, to_y, apex_x, apex_y, out_color
  output logic [((6*COORD_BITS+cbsg_pkg::COLOR_W+7)/8)*8-1:0]
                              m_axis_tdata,
  // is_triangle
  output logic [0:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int CB  = COORD_BITS;
  localparam int SB  = $clog2(MAX_STEPS + 1);
  localparam int SW  = (SB > cbsg_pkg::STEPS_W) ? SB : cbsg_pkg::STEPS_W;
  localparam int DW  = 3 * SB;
  localparam int MW  = DW + CB;
  localparam int OW  = ((6*CB+cbsg_pkg::COLOR_W+7)/8)*8;
  localparam int SOF = 8 * CB;
  localparam int COF = SOF + cbsg_pkg::STEPS_W;

  logic                 busy_q;
  logic [SB-1:0]        k_q, n_q;
  logic [8*CB-1:0]      pts_q;
  logic                 fill_q;
  logic [cbsg_pkg::COLOR_W-1:0] color_q;
  logic                 adv;
  logic                 s_accept;
  logic [SW-1:0]        steps_ext;
  logic [SB-1:0]        n_d;
  cbsg_pkg::ctl_t       seq_ctl;

  logic                 w_vld, c_vld, q_vld;
  cbsg_pkg::ctl_t       w_ctl, c_ctl, q_ctl;
  logic [3:0][DW-1:0]   w;
  logic [DW-1:0]        w_d3, c_d3;
  logic [8*CB-1:0]      w_pts;
  logic [1:0][MW-1:0]   c_mag;
  logic [1:0]           c_neg, q_neg;
  logic [2*CB-1:0]      c_p0, q_p0;
  logic [1:0][CB-1:0]   q_quo;

  logic                 out_vld_q;
  cbsg_pkg::ctl_t       out_ctl_q;
  logic [CB-1:0]        from_x_q, from_y_q, to_x_q, to_y_q, apex_x_q, apex_y_q;
  logic [1:0][CB-1:0]   pt_d;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !busy_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // step count: zero means one, clamp to the largest supported count
  always_comb begin
    steps_ext = SW'(s_axis_tdata[SOF +: cbsg_pkg::STEPS_W]);
    if (steps_ext == '0) begin
      n_d = SB'(1);
    end else if (steps_ext > SW'(MAX_STEPS)) begin
      n_d = SB'(MAX_STEPS);
    end else begin
      n_d = SB'(steps_ext);
    end
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      n_q    <= '0;
    end else if (s_accept) begin
      busy_q <= 1'b1;
      k_q    <= SB'(1);
      n_q    <= n_d;
    end else if (busy_q && adv) begin
      k_q <= k_q + SB'(1);
      if (k_q == n_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pts_q   <= s_axis_tdata[8*CB-1:0];
      fill_q  <= s_axis_tuser[0];
      color_q <= s_axis_tdata[COF +: cbsg_pkg::COLOR_W];
    end
  end

  always_comb begin
    seq_ctl.first = (k_q == SB'(1));
    seq_ctl.last  = (k_q == n_q);
    seq_ctl.fill  = fill_q;
    seq_ctl.color = color_q;
  end

  cbsg_weights #(.SB(SB), .DW(DW), .CB(CB)) u_weights (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (busy_q),
    .ctl_i  (seq_ctl),
    .k_i    (k_q),
    .u_i    (n_q - k_q),
    .n_i    (n_q),
    .pts_i  (pts_q),
    .vld_o  (w_vld),
    .ctl_o  (w_ctl),
    .w_o    (w),
    .d_o    (w_d3),
    .pts_o  (w_pts)
  );

  cbsg_combine #(.DW(DW), .CB(CB)) u_combine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (w_vld),
    .ctl_i  (w_ctl),
    .w_i    (w),
    .d_i    (w_d3),
    .pts_i  (w_pts),
    .vld_o  (c_vld),
    .ctl_o  (c_ctl),
    .mag_o  (c_mag),
    .neg_o  (c_neg),
    .d_o    (c_d3),
    .p0_o   (c_p0)
  );

  cbsg_divide #(.DW(DW), .CB(CB)) u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (c_vld),
    .ctl_i  (c_ctl),
    .mag_i  (c_mag),
    .neg_i  (c_neg),
    .d_i    (c_d3),
    .p0_i   (c_p0),
    .vld_o  (q_vld),
    .ctl_o  (q_ctl),
    .quo_o  (q_quo),
    .neg_o  (q_neg),
    .p0_o   (q_p0)
  );

  // restore the sign, truncation toward zero
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      pt_d[a] = q_neg[a] ? -q_quo[a] : q_quo[a];
    end
  end

  // output register; the previous point is the one still held here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && q_vld) begin
      out_ctl_q <= q_ctl;
      from_x_q  <= q_ctl.first ? q_p0[CB-1:0]    : to_x_q;
      from_y_q  <= q_ctl.first ? q_p0[2*CB-1:CB] : to_y_q;
      to_x_q    <= pt_d[0];
      to_y_q    <= pt_d[1];
      apex_x_q  <= q_ctl.fill ? q_p0[CB-1:0]    : '0;
      apex_y_q  <= q_ctl.fill ? q_p0[2*CB-1:CB] : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OW'({out_ctl_q.color, apex_y_q, apex_x_q,
                              to_y_q, to_x_q, from_y_q, from_x_q});
  assign m_axis_tuser  = out_ctl_q.fill;
  assign m_axis_tlast  = out_ctl_q.last;

  // assertions
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q != '0) && (k_q <= n_q))
    else $error("step index outside the active count");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> busy_q && (k_q == SB'(1)))
    else $error("sequencer did not start at the first step");

  a_fan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ctl_q.first && out_ctl_q.fill) |->
      (from_x_q == apex_x_q) && (from_y_q == apex_y_q))
    else $error("first fan triangle does not start at its apex");

  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && adv && (k_q == n_q)) |=> !busy_q)
    else $error("sequencer ran past the last step");

endmodule
